/* design/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the record decision controller
// Item formats, configuration fields, decision state and result packing.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [31:0] RETRY_GAP_MS = 32'd1000;

    typedef enum logic [1:0] {
        EVT_RC_SAMPLE = 2'd0,
        EVT_UPDATE    = 2'd1,
        EVT_START     = 2'd2,
        EVT_STOP      = 2'd3
    } t_evt_kind;

    typedef enum logic [1:0] {
        REC_NONE  = 2'd0,
        REC_START = 2'd1,
        REC_STOP  = 2'd2
    } t_rec_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWITCH_THRESHOLD = 2'd0,
        CFG_DEBOUNCE         = 2'd1,
        CFG_RECORD_ON_ARM    = 2'd2,
        CFG_STOP_ON_DISARM   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_evt_kind   cmd;
        logic [11:0] rc_pulse_us;
        logic [31:0] now_ms;
        logic        fc_alive;
        logic        fc_armed;
        logic        cam_ready;
        logic        cam_accepts;
    } t_in_item;

    typedef struct packed {
        t_rec_cmd    sent_command;
        logic        switch_on;
        logic        want_recording;
        t_rec_cmd    pending_command;
        logic [11:0] last_pulse_us;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [11:0] switch_threshold_us;
        logic [15:0] debounce_ms;
        logic        record_on_arm;
        logic        stop_on_disarm;
    } t_cfg;

    typedef struct packed {
        logic        debounced_on;
        logic        raw_on;
        logic [31:0] raw_change_time;
        logic        pulse_seen;
        logic [11:0] stored_pulse;
        logic        arm_latch;
        logic        arm_suppress;
        logic        wanted;
        t_rec_cmd    deferred;
        logic        prev_armed;
        logic        arm_seen;
        logic [31:0] retry_time;
    } t_rdc_state;

    // Results of one event: always a first item, a second one when two is set
    typedef struct packed {
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_rdc_batch;

    function automatic t_out_item mk_result(t_rec_cmd sent, t_rdc_state st, logic last);
        t_out_item r;
        r.sent_command    = sent;
        r.switch_on       = st.debounced_on;
        r.want_recording  = st.wanted;
        r.pending_command = st.deferred;
        r.last_pulse_us   = st.stored_pulse;
        r.last_result     = last;
        return r;
    endfunction

endpackage

/* design/rdc_cfg.sv */
// ----------------------------------------------------------------------------
// rdc_cfg: configuration registers
// Plain write-only register file, indexed by register number.
// ----------------------------------------------------------------------------
module rdc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rdc_pkg::t_cfg                   o_cfg
);
    import rdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_threshold_us <= 12'd1500;
            r_cfg.debounce_ms         <= 16'd100;
            r_cfg.record_on_arm       <= 1'b0;
            r_cfg.stop_on_disarm      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SWITCH_THRESHOLD: r_cfg.switch_threshold_us <= i_cfg_data[11:0];
                CFG_DEBOUNCE:         r_cfg.debounce_ms         <= i_cfg_data[15:0];
                CFG_RECORD_ON_ARM:    r_cfg.record_on_arm       <= i_cfg_data[0];
                CFG_STOP_ON_DISARM:   r_cfg.stop_on_disarm      <= i_cfg_data[0];
                default:              r_cfg                     <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/rdc_decide.sv */
// ----------------------------------------------------------------------------
// rdc_decide: decision state and per-event logic
// Debounce, arm latch, wanted state and send/retry of camera commands.
// ----------------------------------------------------------------------------
module rdc_decide (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  rdc_pkg::t_in_item     i_item,
    input  rdc_pkg::t_cfg         i_cfg,
    output rdc_pkg::t_rdc_batch   o_batch
);
    import rdc_pkg::*;

    t_rdc_state r_st;
    t_rdc_state n_st;
    t_rdc_state st_chg;

    logic        raw_new;
    logic        rising;
    logic        want_new;
    logic        chg_hit;
    logic        retry_hit;
    t_rec_cmd    chg_cmd;
    t_rec_cmd    retry_cmd;
    logic [31:0] since_raw;
    logic [31:0] since_retry;
    logic        debounce_done;
    logic        retry_due;

    assign since_raw     = i_item.now_ms - r_st.raw_change_time;
    assign since_retry   = i_item.now_ms - r_st.retry_time;
    assign debounce_done = since_raw >= {16'd0, i_cfg.debounce_ms};
    assign retry_due     = since_retry >= RETRY_GAP_MS;
    assign raw_new       = i_item.rc_pulse_us > i_cfg.switch_threshold_us;

    always_comb begin
        n_st      = r_st;
        st_chg    = r_st;
        rising    = 1'b0;
        want_new  = 1'b0;
        chg_hit   = 1'b0;
        retry_hit = 1'b0;
        chg_cmd   = REC_NONE;
        retry_cmd = REC_NONE;
        o_batch   = '0;
        unique case (i_item.cmd)
            EVT_RC_SAMPLE: begin
                n_st.stored_pulse = i_item.rc_pulse_us;
                n_st.pulse_seen   = 1'b1;
                if (raw_new != r_st.raw_on) begin
                    n_st.raw_on          = raw_new;
                    n_st.raw_change_time = i_item.now_ms;
                end
                o_batch.first = mk_result(REC_NONE, n_st, 1'b1);
            end
            EVT_UPDATE: begin
                if (r_st.pulse_seen && r_st.raw_on != r_st.debounced_on && debounce_done) begin
                    n_st.debounced_on = r_st.raw_on;
                    n_st.arm_latch    = 1'b0;
                    n_st.arm_suppress = 1'b0;
                end
                if (i_item.fc_alive && (!r_st.arm_seen || i_item.fc_armed != r_st.prev_armed)) begin
                    rising          = i_item.fc_armed && !r_st.prev_armed;
                    n_st.prev_armed = i_item.fc_armed;
                    n_st.arm_seen   = 1'b1;
                    if (rising && i_cfg.record_on_arm && !n_st.debounced_on
                            && !n_st.arm_suppress) begin
                        n_st.arm_latch = 1'b1;
                    end
                    if (!rising && i_cfg.stop_on_disarm) begin
                        n_st.arm_latch    = 1'b0;
                        n_st.arm_suppress = 1'b0;
                    end
                    if (!i_item.fc_armed) begin
                        n_st.arm_suppress = 1'b0;
                    end
                end
                want_new = n_st.debounced_on || n_st.arm_latch;
                // State change: send start or stop
                if (want_new != r_st.wanted) begin
                    chg_hit       = 1'b1;
                    chg_cmd       = want_new ? REC_START : REC_STOP;
                    n_st.wanted   = want_new;
                    n_st.deferred = i_item.cam_accepts ? REC_NONE : chg_cmd;
                end
                st_chg = n_st;
                // Retry of a refused command, paced by the retry gap
                if (n_st.deferred != REC_NONE && i_item.cam_ready && retry_due) begin
                    retry_hit       = 1'b1;
                    retry_cmd       = n_st.deferred;
                    n_st.retry_time = i_item.now_ms;
                    n_st.deferred   = i_item.cam_accepts ? REC_NONE : retry_cmd;
                end
                priority if (chg_hit) begin
                    o_batch.two    = retry_hit;
                    o_batch.first  = mk_result(chg_cmd, st_chg, !retry_hit);
                    o_batch.second = mk_result(retry_cmd, n_st, 1'b1);
                end else if (retry_hit) begin
                    o_batch.first  = mk_result(retry_cmd, n_st, 1'b1);
                end else begin
                    o_batch.first  = mk_result(REC_NONE, n_st, 1'b1);
                end
            end
            EVT_START: begin
                n_st.arm_latch    = i_cfg.record_on_arm;
                n_st.arm_suppress = 1'b0;
                n_st.wanted       = 1'b1;
                n_st.deferred     = i_item.cam_accepts ? REC_NONE : REC_START;
                o_batch.first     = mk_result(REC_START, n_st, 1'b1);
            end
            EVT_STOP: begin
                n_st.arm_latch    = 1'b0;
                n_st.arm_suppress = i_cfg.record_on_arm && i_item.fc_armed
                                    && !i_cfg.stop_on_disarm;
                n_st.wanted       = 1'b0;
                n_st.deferred     = i_item.cam_accepts ? REC_NONE : REC_STOP;
                o_batch.first     = mk_result(REC_STOP, n_st, 1'b1);
            end
            default: begin
                o_batch.first = mk_result(REC_NONE, r_st, 1'b1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

endmodule

/* design/rdc_outbuf.sv */
// ----------------------------------------------------------------------------
// rdc_outbuf: result buffer
// Two-entry result register; loads a batch of one or two items, drains in order.
// ----------------------------------------------------------------------------
module rdc_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  rdc_pkg::t_rdc_batch   i_batch,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rdc_pkg::t_out_item    o_item
);
    import rdc_pkg::*;

    logic [1:0] r_cnt;
    t_out_item  r_head;
    t_out_item  r_tail;
    logic       pop;

    assign o_valid = r_cnt != 2'd0;
    assign pop     = o_valid && !i_stall;
    // Room for a new batch once the buffer drains this cycle
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign o_item  = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_head <= i_batch.first;
            r_tail <= i_batch.second;
        end else if (pop) begin
            r_head <= r_tail;
        end
    end

endmodule

/* design/record_decision_controller_core.sv */
// ----------------------------------------------------------------------------
// record_decision_controller_core: camera record decision controller
// Timed events in, camera start/stop decisions out, one result item or two per event.
// ----------------------------------------------------------------------------
// Each accepted item is one timed event (RC sample, update, manual start or
// manual stop). It is held in an input register, evaluated combinationally
// against the decision state, and its one or two results are loaded into a
// two-entry output buffer that offers them in order. The output port moves
// one result item per cycle while not stalled, which sets the rate: events
// that give one result go through at one item per cycle; an update that sends
// a change and a retry holds the next event back until the buffer has room.
// The last item of each event carries last_result. Configuration writes take
// effect at once; the user must make them while idle: the block does not enforce it.
module record_decision_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // event input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rdc_pkg::t_in_item               i_in_item,
    // result output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rdc_pkg::t_out_item              o_out_item
);
    import rdc_pkg::*;

    t_cfg       cfg;
    t_rdc_batch batch;
    logic       room;
    logic       fire;
    logic       in_take;

    logic       r_in_valid;
    t_in_item   r_in_item;

    // Evaluate the held item as soon as the buffer can take its results
    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload until evaluated
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    rdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rdc_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_batch (batch)
    );

    rdc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_batch (batch),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

/* tb/sv/record_decision_controller_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_decision_controller_core_tb: self-checking bench of the record decision core
// Feeds timed events through the valid/stall input channel, predicts every
// decision item from its own model of the controller, and checks the result
// channel item by item under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module record_decision_controller_core_tb;

    import rdc_pkg::*;

    // ------------------------------------------------------------------------
    // Decision scoreboard: own copy of registers and state, queue of the
    // decision items still owed by the core.
    // ------------------------------------------------------------------------
    class record_decision_scoreboard;
        t_cfg       regs;
        t_rdc_state st;
        t_out_item  owed_decisions[$];
        int         errors;
        int         checked;
        int         events;
        int         double_sends;

        function new();
            regs.switch_threshold_us = 12'd1500;
            regs.debounce_ms         = 16'd100;
            regs.record_on_arm       = 1'b0;
            regs.stop_on_disarm      = 1'b1;
            st           = '0;
            errors       = 0;
            checked      = 0;
            events       = 0;
            double_sends = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SWITCH_THRESHOLD: regs.switch_threshold_us = data[11:0];
                CFG_DEBOUNCE:         regs.debounce_ms         = data[15:0];
                CFG_RECORD_ON_ARM:    regs.record_on_arm       = data[0];
                CFG_STOP_ON_DISARM:   regs.stop_on_disarm      = data[0];
            endcase
        endfunction

        function void drop_intent();
            st.arm_latch    = 1'b0;
            st.arm_suppress = 1'b0;
        endfunction

        // A refused command stays deferred, an accepted one clears it
        function void issue(t_rec_cmd c, logic accepts);
            st.deferred = accepts ? REC_NONE : c;
        endfunction

        function t_out_item snapshot(t_rec_cmd sent);
            t_out_item r;
            r.sent_command    = sent;
            r.switch_on       = st.debounced_on;
            r.want_recording  = st.wanted;
            r.pending_command = st.deferred;
            r.last_pulse_us   = st.stored_pulse;
            r.last_result     = 1'b0;
            return r;
        endfunction

        function void note_event(t_in_item ev);
            t_out_item   batch [2];
            int          n;
            t_rec_cmd    c;
            logic        nw;
            logic        rising;
            logic [31:0] held;
            logic [31:0] since_retry;
            n = 0;
            events++;
            held        = ev.now_ms - st.raw_change_time;
            since_retry = ev.now_ms - st.retry_time;
            case (ev.cmd)
                EVT_RC_SAMPLE: begin
                    st.stored_pulse = ev.rc_pulse_us;
                    st.pulse_seen   = 1'b1;
                    if ((ev.rc_pulse_us > regs.switch_threshold_us) != st.raw_on) begin
                        st.raw_on          = ~st.raw_on;
                        st.raw_change_time = ev.now_ms;
                    end
                    batch[n] = snapshot(REC_NONE);
                    n++;
                end
                EVT_UPDATE: begin
                    if (st.pulse_seen && st.raw_on != st.debounced_on &&
                        held >= {16'd0, regs.debounce_ms}) begin
                        st.debounced_on = st.raw_on;
                        drop_intent();
                    end
                    if (ev.fc_alive && (!st.arm_seen || ev.fc_armed != st.prev_armed)) begin
                        rising        = ev.fc_armed && !st.prev_armed;
                        st.prev_armed = ev.fc_armed;
                        st.arm_seen   = 1'b1;
                        if (rising && regs.record_on_arm && !st.debounced_on &&
                            !st.arm_suppress)
                            st.arm_latch = 1'b1;
                        if (!rising && regs.stop_on_disarm)
                            drop_intent();
                        if (!ev.fc_armed)
                            st.arm_suppress = 1'b0;
                    end
                    nw = st.debounced_on || st.arm_latch;
                    if (nw != st.wanted) begin
                        c         = nw ? REC_START : REC_STOP;
                        st.wanted = nw;
                        issue(c, ev.cam_accepts);
                        batch[n] = snapshot(c);
                        n++;
                    end
                    if (st.deferred != REC_NONE && ev.cam_ready &&
                        since_retry >= RETRY_GAP_MS) begin
                        c             = st.deferred;
                        st.retry_time = ev.now_ms;
                        issue(c, ev.cam_accepts);
                        batch[n] = snapshot(c);
                        n++;
                    end
                    if (n == 0) begin
                        batch[n] = snapshot(REC_NONE);
                        n++;
                    end
                end
                EVT_START: begin
                    drop_intent();
                    if (regs.record_on_arm)
                        st.arm_latch = 1'b1;
                    st.wanted = 1'b1;
                    issue(REC_START, ev.cam_accepts);
                    batch[n] = snapshot(REC_START);
                    n++;
                end
                default: begin
                    drop_intent();
                    st.wanted = 1'b0;
                    if (regs.record_on_arm && ev.fc_armed && !regs.stop_on_disarm)
                        st.arm_suppress = 1'b1;
                    issue(REC_STOP, ev.cam_accepts);
                    batch[n] = snapshot(REC_STOP);
                    n++;
                end
            endcase
            batch[n-1].last_result = 1'b1;
            if (n == 2)
                double_sends++;
            for (int i = 0; i < n; i++)
                owed_decisions.push_back(batch[i]);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_decisions.size() == 0) begin
                errors++;
                $display("%0t: result item %h with no event waiting", $time, got);
                return;
            end
            want = owed_decisions.pop_front();
            checked++;
            compare_field("sent_command", 32'(want.sent_command), 32'(got.sent_command));
            compare_field("switch_on", 32'(want.switch_on), 32'(got.switch_on));
            compare_field("want_recording", 32'(want.want_recording),
                          32'(got.want_recording));
            compare_field("pending_command", 32'(want.pending_command),
                          32'(got.pending_command));
            compare_field("last_pulse_us", 32'(want.last_pulse_us), 32'(got.last_pulse_us));
            compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
        endfunction

        function int owed();
            return owed_decisions.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;

    record_decision_controller_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    record_decision_scoreboard sb;

    // Idle pattern of the current phase, in percent per cycle
    int unsigned in_idle_pct;
    int unsigned out_stall_pct;

    // Stimulus-side view of the world: clock of the events, stick position,
    // arm switch and the registers currently programmed
    logic [31:0] sim_now;
    logic        sim_stick_on;
    logic        sim_armed;
    int unsigned cur_thr;
    int unsigned cur_deb;
    int          items_sent;
    int          phases_run;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the core hangs
    // ------------------------------------------------------------------------
    initial begin
        #4_000_000;
        $display("record_decision_controller_core_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random with the rate of the current phase
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitors: sample both handshakes on the pre-edge values
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_event(i_in_item);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_item);
    end

    // ------------------------------------------------------------------------
    // Sender: offer one item, hold it until accepted. The caller stands just
    // after a rising edge; valid stays high when the next item follows at once.
    // ------------------------------------------------------------------------
    task automatic push_event(input t_in_item ev);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do
            @(posedge i_clk);
        while (o_in_stall);
        items_sent++;
    endtask

    task automatic directed_event(input t_evt_kind cmd, input logic [11:0] pulse,
                                  input logic [31:0] now, input logic alive,
                                  input logic armed, input logic ready,
                                  input logic accepts);
        t_in_item ev;
        ev.cmd         = cmd;
        ev.rc_pulse_us = pulse;
        ev.now_ms      = now;
        ev.fc_alive    = alive;
        ev.fc_armed    = armed;
        ev.cam_ready   = ready;
        ev.cam_accepts = accepts;
        push_event(ev);
    endtask

    // Hold the sender off until every owed decision has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Write all four registers; the core is idle here
    task automatic program_regs(input t_cfg c);
        cfg_write(CFG_SWITCH_THRESHOLD, {4'd0, c.switch_threshold_us});
        cfg_write(CFG_DEBOUNCE, c.debounce_ms);
        cfg_write(CFG_RECORD_ON_ARM, {15'd0, c.record_on_arm});
        cfg_write(CFG_STOP_ON_DISARM, {15'd0, c.stop_on_disarm});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_thr = 32'(c.switch_threshold_us);
        cur_deb = 32'(c.debounce_ms);
    endtask

    // ------------------------------------------------------------------------
    // Random event: mostly a plausible flight (stick moves, arm edges, updates
    // at ms rates), with some time jumps and noise fields mixed in.
    // ------------------------------------------------------------------------
    function automatic t_in_item random_event();
        t_in_item    ev;
        int unsigned sel;
        int unsigned dt;
        int unsigned lo;
        sel = $urandom_range(99);
        if (sel < 34)
            ev.cmd = EVT_RC_SAMPLE;
        else if (sel < 80)
            ev.cmd = EVT_UPDATE;
        else if (sel < 90)
            ev.cmd = EVT_START;
        else
            ev.cmd = EVT_STOP;

        // Advance time: short steps, retry-sized steps, debounce-sized steps,
        // and now and then an arbitrary jump that wraps the counter
        sel = $urandom_range(99);
        if (sel < 65)
            dt = $urandom_range(120);
        else if (sel < 88)
            dt = $urandom_range(1200);
        else if (sel < 98)
            dt = $urandom_range(cur_deb + cur_deb / 4 + 100);
        else
            dt = $urandom();
        sim_now   = sim_now + dt;
        ev.now_ms = sim_now;

        // Move the stick now and then; pulses follow it except for noise
        if ($urandom_range(99) < 15)
            sim_stick_on = ~sim_stick_on;
        lo = (cur_thr >= 4095) ? 4095 : cur_thr + 1;
        sel = $urandom_range(99);
        if (sel < 10)
            ev.rc_pulse_us = 12'($urandom_range(4095));
        else if (sim_stick_on)
            ev.rc_pulse_us = 12'($urandom_range(4095, lo));
        else
            ev.rc_pulse_us = 12'($urandom_range(cur_thr));

        if ($urandom_range(99) < 8)
            sim_armed = ~sim_armed;
        ev.fc_armed    = ($urandom_range(99) < 5) ? ~sim_armed : sim_armed;
        ev.fc_alive    = ($urandom_range(99) < 88);
        ev.cam_ready   = ($urandom_range(99) < 70);
        ev.cam_accepts = ($urandom_range(99) < 70);
        return ev;
    endfunction

    // Idle patterns: none, sender only, receiver only, both
    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1: begin in_idle_pct = 59; out_stall_pct = 0;  end
            2: begin in_idle_pct = 0;  out_stall_pct = 59; end
            default: begin in_idle_pct = 37; out_stall_pct = 37; end
        endcase
    endtask

    task automatic run_phase(input t_cfg c, input int n_items, input int mode,
                             input logic [31:0] start_ms);
        drain_results();
        program_regs(c);
        set_idle_mode(mode);
        sim_now = start_ms;
        phases_run++;
        for (int i = 0; i < n_items; i++) begin
            // Pause the sender halfway, and now and then at random, until the core has caught up
            if (i == n_items / 2 || $urandom_range(199) == 0)
                drain_results();
            push_event(random_event());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg ph;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_stall   = 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        sim_now       = '0;
        sim_stick_on  = 1'b0;
        sim_armed     = 1'b0;
        cur_thr       = 1500;
        cur_deb       = 100;
        items_sent    = 0;
        phases_run    = 0;

        // Hold reset, then release it synchronously
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part at reset register values ----
        // update before any rc sample: switch must not debounce
        directed_event(EVT_UPDATE,    12'd0,    32'd0,    1'b0, 1'b0, 1'b1, 1'b1);
        // pulse equal to threshold stays off, a full-scale one turns raw on
        directed_event(EVT_RC_SAMPLE, 12'd1500, 32'd5,    1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_RC_SAMPLE, 12'd4095, 32'd10,   1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd60,   1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd110,  1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_RC_SAMPLE, 12'd0,    32'd200,  1'b1, 1'b0, 1'b1, 1'b1);
        // stop refused, then retry too early, then retry accepted
        directed_event(EVT_UPDATE,    12'd0,    32'd300,  1'b1, 1'b0, 1'b0, 1'b0);
        directed_event(EVT_UPDATE,    12'd0,    32'd600,  1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd1300, 1'b1, 1'b0, 1'b1, 1'b1);
        // manual start refused, manual stop while armed with telemetry dead
        directed_event(EVT_START,     12'd0,    32'd1400, 1'b1, 1'b0, 1'b1, 1'b0);
        directed_event(EVT_STOP,      12'd1501, 32'd1500, 1'b0, 1'b1, 1'b1, 1'b1);
        // change send and retry in one update, both refused
        directed_event(EVT_RC_SAMPLE, 12'd1501, 32'd2000, 1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd2400, 1'b1, 1'b0, 1'b1, 1'b0);
        directed_event(EVT_UPDATE,    12'd0,    32'd3500, 1'b1, 1'b0, 1'b1, 1'b1);

        // ---- Directed part with arm latch on, disarm keeps latch ----
        drain_results();
        ph = '{switch_threshold_us: 12'd4095, debounce_ms: 16'd0,
               record_on_arm: 1'b1, stop_on_disarm: 1'b0};
        program_regs(ph);
        directed_event(EVT_RC_SAMPLE, 12'd4095, 32'd3600, 1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd3600, 1'b1, 1'b0, 1'b1, 1'b1);
        // arming latches recording on
        directed_event(EVT_UPDATE,    12'd0,    32'd3700, 1'b1, 1'b1, 1'b1, 1'b1);
        // manual stop while armed sets suppression even with telemetry dead
        directed_event(EVT_STOP,      12'd0,    32'd3800, 1'b0, 1'b1, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd3900, 1'b1, 1'b0, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd4000, 1'b1, 1'b1, 1'b1, 1'b1);
        directed_event(EVT_START,     12'd0,    32'd4100, 1'b1, 1'b1, 1'b1, 1'b0);
        directed_event(EVT_UPDATE,    12'd0,    32'd5200, 1'b0, 1'b1, 1'b1, 1'b1);
        // all-ones and all-zeros fields, time wrapping
        directed_event(EVT_RC_SAMPLE, 12'hFFF,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        directed_event(EVT_UPDATE,    12'd0,    32'd0,    1'b1, 1'b0, 1'b0, 1'b0);

        // ---- Random phases over several register settings ----
        run_phase('{switch_threshold_us: 12'd1500, debounce_ms: 16'd100,
                    record_on_arm: 1'b1, stop_on_disarm: 1'b1}, 260, 0, 32'd10_000);
        run_phase('{switch_threshold_us: 12'd0, debounce_ms: 16'd0,
                    record_on_arm: 1'b1, stop_on_disarm: 1'b0}, 260, 1, $urandom());
        run_phase('{switch_threshold_us: 12'd4095, debounce_ms: 16'hFFFF,
                    record_on_arm: 1'b0, stop_on_disarm: 1'b0}, 260, 2, $urandom());
        ph.switch_threshold_us = 12'($urandom_range(4095));
        ph.debounce_ms         = 16'($urandom_range(400));
        ph.record_on_arm       = 1'b1;
        ph.stop_on_disarm      = 1'b0;
        run_phase(ph, 260, 3, $urandom());
        // times just below the wrap of the ms counter
        run_phase('{switch_threshold_us: 12'd2000, debounce_ms: 16'd250,
                    record_on_arm: 1'b1, stop_on_disarm: 1'b1}, 260, 3, 32'hFFFF_F000);

        // ---- Wind down: wait for the last decisions ----
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d events over %0d register phases; %0d decision items checked,",
                 items_sent, phases_run + 2, sb.checked);
        $display("%0d updates issued both a change and a retry.", sb.double_sends);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("record_decision_controller_core_tb passed");
        end else begin
            $display("record_decision_controller_core_tb failed");
        end
        $finish;
    end

endmodule
